>>> sv/chacha20_stream_xor_assert.svh
// assertion macros for the chacha20 stream block
// used by the top level only
`ifndef CHACHA20_STREAM_XOR_ASSERT_SVH
`define CHACHA20_STREAM_XOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CSX_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("fail");
`define CSX_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("fail");
`else
`define CSX_ASSERT_IMP(label, clk, rst, a, c)
`define CSX_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

>>> sv/csx_pkg.sv
// shared constants and types for the chacha20 stream block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package csx_pkg;
  localparam int DefaultRoundCount = 20;
  localparam logic [31:0] Sigma0 = 32'h61707865;
  localparam logic [31:0] Sigma1 = 32'h3320646e;
  localparam logic [31:0] Sigma2 = 32'h79622d32;
  localparam logic [31:0] Sigma3 = 32'h6b206574;
  localparam logic [2:0] RegKey01 = 3'd0;
  localparam logic [2:0] RegKey23 = 3'd1;
  localparam logic [2:0] RegKey45 = 3'd2;
  localparam logic [2:0] RegKey67 = 3'd3;
  localparam logic [2:0] RegNonce01 = 3'd4;
  localparam logic [2:0] RegNonce2 = 3'd5;

  typedef logic [15:0][31:0] blk_t;

  // word queued between front and back
  typedef struct packed {
    logic [7:0] data;
    logic [5:0] pos;
    logic       gen;
    logic [31:0] ctr;
    logic [31:0] ctr_hi;
  } qword_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  // one quarter round on four words
  function automatic logic [127:0] qr(input logic [31:0] a0, input logic [31:0] b0,
                                      input logic [31:0] c0, input logic [31:0] d0);
    logic [31:0] a, b, c, d;
    a = a0; b = b0; c = c0; d = d0;
    a = a + b; d = rotl(d ^ a, 16);
    c = c + d; b = rotl(b ^ c, 12);
    a = a + b; d = rotl(d ^ a, 8);
    c = c + d; b = rotl(b ^ c, 7);
    qr = {a, b, c, d};
  endfunction
endpackage
`default_nettype wire

>>> sv/chacha20_stream_xor.sv
// chacha20 stream xor, one byte word in, one byte word out
// channels: in (data_byte, new_message) and out (out_byte), valid/stall each.
// config: cfg_we/cfg_index/cfg_data write key and nonce registers; the user
// must write them only while idle, the block does not enforce it. a word at
// byte position zero starts a new 64-byte keystream block; the back end runs
// ROUND_COUNT rounds, one per cycle, before that word leaves. the other 63
// bytes of the block pass one per cycle while nothing stalls, through the
// queue register and the output register; the single round unit sets the
// sustained rate. a one-entry queue parts front and back; the output register
// holds a word while the receiver stalls and back pressure reaches in_stall.
// reset clears registers, counter, counter high word and byte position.
// depends on csx_pkg, csx_front, csx_back and the assertion header
`timescale 1ns / 1ps
`default_nettype none
`include "chacha20_stream_xor_assert.svh"
module chacha20_stream_xor
  import csx_pkg::*;
#(
  parameter int ROUND_COUNT = DefaultRoundCount
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        new_message,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte
);
  logic [255:0] key;
  logic [31:0]  nw0, nw1, nw2;
  logic         q_valid, q_stall;
  qword_t       q_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
      nw0 <= '0;
      nw1 <= '0;
      nw2 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegKey01:   key[63:0] <= cfg_data;
        RegKey23:   key[127:64] <= cfg_data;
        RegKey45:   key[191:128] <= cfg_data;
        RegKey67:   key[255:192] <= cfg_data;
        RegNonce01: {nw1, nw0} <= cfg_data;
        RegNonce2:  nw2 <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  csx_front u_front (
    .clk, .rst, .nonce_w0(nw0), .in_valid, .in_stall, .data_byte, .new_message,
    .q_valid, .q_stall, .q_word
  );

  csx_back #(.ROUND_COUNT(ROUND_COUNT)) u_back (
    .clk, .rst, .key, .nonce_w1(nw1), .nonce_w2(nw2), .q_valid, .q_stall, .q_word,
    .out_valid, .out_stall, .out_byte
  );

  `CSX_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_byte))
  `CSX_ASSERT_IMP(a_q_hold, clk, rst, q_valid && q_stall && in_valid, in_stall)
  `CSX_ASSERT_NXT(a_in_to_q, clk, rst, in_valid && !in_stall, q_valid)
endmodule
`default_nettype wire

>>> sv/csx_front.sv
// front: accepts words, tracks byte position and block counter
// depends on csx_pkg
`timescale 1ns / 1ps
`default_nettype none
module csx_front
  import csx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] nonce_w0,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        new_message,
  output logic             q_valid,
  input  wire logic        q_stall,
  output qword_t           q_word
);
  logic [5:0]  pos;
  logic [31:0] ctr;
  logic [31:0] ctr_hi;
  logic        full;
  qword_t      held;
  logic [5:0]  p;
  logic [31:0] c, h;
  logic        take;

  assign in_stall = full && q_stall;
  assign take = in_valid && !in_stall;
  assign q_valid = full;
  assign q_word = held;

  always_comb begin
    p = new_message ? 6'd0 : pos;
    c = new_message ? 32'd0 : ctr;
    h = new_message ? nonce_w0 : ctr_hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      ctr <= '0;
      ctr_hi <= '0;
      full <= 1'b0;
    end else begin
      if (take) begin
        full <= 1'b1;
        held <= '{data: data_byte, pos: p, gen: (p == 6'd0), ctr: c, ctr_hi: h};
        pos <= p + 6'd1;
        if (p == 6'd63) begin
          ctr <= c + 32'd1;
          ctr_hi <= (c == 32'hffffffff) ? h + 32'd1 : h;
        end else begin
          ctr <= c;
          ctr_hi <= h;
        end
      end else if (!q_stall) begin
        full <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

>>> sv/csx_back.sv
// back: computes a keystream block one round per cycle and xors bytes
// depends on csx_pkg
`timescale 1ns / 1ps
`default_nettype none
module csx_back
  import csx_pkg::*;
#(
  parameter int ROUND_COUNT = DefaultRoundCount
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [255:0] key,
  input  wire logic [31:0]  nonce_w1,
  input  wire logic [31:0]  nonce_w2,
  input  wire logic         q_valid,
  output logic              q_stall,
  input  wire qword_t       q_word,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [7:0]        out_byte
);
  localparam int RW = $clog2(ROUND_COUNT + 1);
  localparam logic [RW-1:0] RoundLast = RW'(ROUND_COUNT);

  blk_t        init, work, ks;
  logic        busy;
  logic [RW-1:0] rnd;
  blk_t        rnext;
  logic [31:0] w;
  logic        can_out;

  assign can_out = !out_valid || !out_stall;
  assign q_stall = !(q_valid && !q_word.gen && !busy && can_out) &&
                   !(q_valid && q_word.gen && busy && rnd == RoundLast && can_out);

  always_comb begin
    rnext = work;
    if (!rnd[0]) begin
      {rnext[0], rnext[4], rnext[8],  rnext[12]} = qr(work[0], work[4], work[8],  work[12]);
      {rnext[1], rnext[5], rnext[9],  rnext[13]} = qr(work[1], work[5], work[9],  work[13]);
      {rnext[2], rnext[6], rnext[10], rnext[14]} = qr(work[2], work[6], work[10], work[14]);
      {rnext[3], rnext[7], rnext[11], rnext[15]} = qr(work[3], work[7], work[11], work[15]);
    end else begin
      {rnext[0], rnext[5], rnext[10], rnext[15]} = qr(work[0], work[5], work[10], work[15]);
      {rnext[1], rnext[6], rnext[11], rnext[12]} = qr(work[1], work[6], work[11], work[12]);
      {rnext[2], rnext[7], rnext[8],  rnext[13]} = qr(work[2], work[7], work[8],  work[13]);
      {rnext[3], rnext[4], rnext[9],  rnext[14]} = qr(work[3], work[4], work[9],  work[14]);
    end
  end

  always_comb begin
    case (q_word.pos[5:2])
      default: w = ks[q_word.pos[5:2]];
    endcase
    if (q_word.gen) w = work[q_word.pos[5:2]] + init[q_word.pos[5:2]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd <= '0;
      out_valid <= 1'b0;
    end else begin
      if (!busy && q_valid && q_word.gen) begin
        busy <= 1'b1;
        rnd <= '0;
        init <= {nonce_w2, nonce_w1, q_word.ctr_hi, q_word.ctr, key,
                 Sigma3, Sigma2, Sigma1, Sigma0};
        work <= {nonce_w2, nonce_w1, q_word.ctr_hi, q_word.ctr, key,
                 Sigma3, Sigma2, Sigma1, Sigma0};
      end else if (busy && rnd != RoundLast) begin
        work <= rnext;
        rnd <= rnd + RW'(1);
      end
      if (!q_stall) begin
        out_valid <= 1'b1;
        out_byte <= q_word.data ^ w[q_word.pos[1:0]*8 +: 8];
        if (q_word.gen) begin
          busy <= 1'b0;
          for (int i = 0; i < 16; i++) ks[i] <= work[i] + init[i];
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire
